[rtl/core/nlmd_pkg.sv]
// ----------------------------------------------------------------------------
// nlmd_pkg
// Shared types, sizes and the exponent weight table of the non-local-means
// pixel denoiser.
// ----------------------------------------------------------------------------
package nlmd_pkg;

  // window and line store geometry
  localparam int unsigned WinSize    = 9;
  localparam int unsigned Lines      = 8;
  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned MinSize    = 16;
  localparam int unsigned SlotBits   = 3;
  localparam int unsigned ColBits    = 8;
  localparam int unsigned MemAddrW   = SlotBits + ColBits;
  localparam int unsigned MemDepth   = Lines * MaxWidth;

  // arithmetic widths
  localparam int unsigned SumW   = 12;   // 3x3 patch sum of 8-bit pixels
  localparam int unsigned SqW    = 24;   // squared patch difference
  localparam int unsigned ExpW   = 40;   // squared difference times decay
  localparam int unsigned WgtW   = 17;   // Q16 weight, up to 1.0
  localparam int unsigned NumW   = 30;   // weighted pixel sum
  localparam int unsigned DenW   = 22;   // weight sum
  localparam int unsigned ProdW  = WgtW + 8;

  localparam int unsigned ExpLimit = 256;
  localparam logic [63:0] ExpStepQ32 = 64'd4034774528;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DECAY  = 2'd2
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_e;

  // control word from the sequencer to the weight unit
  typedef struct packed {
    logic start;   // clear accumulators
    logic issue;   // candidate enters the pipeline
    logic skip;    // candidate is the center itself
    logic fin;     // fold the largest weight in for the center
  } wctl_t;

  typedef logic [ExpLimit:0][WgtW-1:0] exp_tab_t;

  // exp(-e/16) in Q16, built by repeated Q32 multiplication
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [95:0] v;
    v = 96'd1 << 32;
    for (int i = 0; i <= ExpLimit; i++) begin
      t[i] = WgtW'((v + 96'd32768) >> 16);
      v = ((v * {32'd0, ExpStepQ32}) + (96'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

[rtl/core/nonlocal_means_pixel_denoise.sv]
// ----------------------------------------------------------------------------
// nonlocal_means_pixel_denoise
// Non-local-means denoiser over a 9x9 window with a 7x7 search of 3x3 patches.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | sink      | in_valid_i/in_stall_o  | pixel_i, frame_start_i
//  out     | source    | out_valid_o/out_stall_i| filtered_o, out_row_o, out_col_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A word with no result takes eight line store reads through the single
//  read port plus one window shift. A word with a result adds the 49-step
//  scan through the shared weight unit, its 3-stage drain, the center
//  fold-in and an eight-bit divide. in_stall_o is high while a word is at
//  work. A finished result waits in the output register while the next
//  word is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module nonlocal_means_pixel_denoise
  import nlmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  filtered_o,
  output logic [7:0]  out_row_o,
  output logic [7:0]  out_col_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [8:0]  width_q, height_q;
  logic [15:0] decay_q;
  logic [7:0]  row_cnt_q, col_cnt_q;
  logic [7:0]  row_q, col_q;
  logic [7:0]  pix_q;
  logic [3:0]  rd_cnt_q;
  logic [2:0]  dx_q, dy_q;
  logic        out_valid_q;
  logic [7:0]  filtered_q, out_row_q, out_col_q;

  logic [7:0] win_q [WinSize][WinSize];
  logic [7:0] wk_q  [WinSize][WinSize];
  logic [7:0] colbuf_q [Lines];

  // position logic
  logic [8:0] w_eff, h_eff;
  logic [8:0] rc0, cc0, rc1, cc1, rc2, nc, nr;
  logic       accept;
  logic       emit;

  // datapath control
  logic                rd_en, wr_en;
  logic [MemAddrW-1:0] raddr, waddr;
  logic [7:0]          rdata;
  wctl_t               wctl;
  logic                wbusy;
  logic [NumW-1:0]     num;
  logic [DenW-1:0]     den;
  logic                div_start, div_done;
  logic [7:0]          quo;
  logic                out_load;
  logic [SumW-1:0]     center_sum, cand_sum;

  // 3x3 patch sum around a fixed place
  function automatic logic [SumW-1:0] patch_sum(
    input logic [7:0] a [WinSize][WinSize], input int cy, input int cx);
    logic [SumW-1:0] s;
    s = '0;
    for (int y = -1; y <= 1; y++) begin
      for (int x = -1; x <= 1; x++) begin
        s = s + SumW'(a[cy+y][cx+x]);
      end
    end
    return s;
  endfunction

  // clamp frame size to the supported range
  always_comb begin
    w_eff = width_q;
    if (width_q < 9'(MinSize)) w_eff = 9'(MinSize);
    else if (width_q > 9'(MaxWidth)) w_eff = 9'(MaxWidth);
    h_eff = height_q;
    if (height_q < 9'(MinSize)) h_eff = 9'(MinSize);
    else if (height_q > 9'(MaxHeight)) h_eff = 9'(MaxHeight);
  end

  // place the incoming word and advance the raster counters
  always_comb begin
    rc0 = frame_start_i ? 9'd0 : {1'b0, row_cnt_q};
    cc0 = frame_start_i ? 9'd0 : {1'b0, col_cnt_q};
    rc1 = rc0;
    cc1 = cc0;
    if (cc0 >= w_eff) begin
      cc1 = '0;
      rc1 = rc0 + 9'd1;
    end
    rc2 = (rc1 >= h_eff) ? 9'd0 : rc1;
    nc  = cc1 + 9'd1;
    nr  = rc2;
    if (nc >= w_eff) begin
      nc = '0;
      nr = rc2 + 9'd1;
      if (nr >= h_eff) nr = '0;
    end
  end

  assign accept      = in_valid_i && !in_stall_o;
  assign emit        = (row_q >= 8'(Lines)) && (col_q >= 8'(Lines));
  assign cfg_ready_o = 1'b1;

  // sequencer next state and control
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wctl       = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        rd_en = (rd_cnt_q != 4'(Lines));
        if (rd_cnt_q == 4'(Lines)) state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        state_d = emit ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        wctl.start = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        wctl.issue = 1'b1;
        wctl.skip  = (dx_q == 3'd3) && (dy_q == 3'd3);
        if ((dx_q == 3'd6) && (dy_q == 3'd6)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!wbusy) state_d = ST_FIN;
      end
      ST_FIN: begin
        wctl.fin = 1'b1;
        state_d  = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= 9'd160;
      height_q    <= 9'd120;
      decay_q     <= 16'd291;
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
      rd_cnt_q    <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH:  width_q  <= cfg_data_i[8:0];
          CFG_HEIGHT: height_q <= cfg_data_i[8:0];
          CFG_DECAY:  decay_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        row_cnt_q <= nr[7:0];
        col_cnt_q <= nc[7:0];
        rd_cnt_q  <= '0;
      end else if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + 4'd1;
      end
      if (state_q == ST_LOAD) begin
        dx_q <= '0;
        dy_q <= '0;
      end else if (state_q == ST_SCAN) begin
        if (dx_q == 3'd6) begin
          dx_q <= '0;
          dy_q <= dy_q + 3'd1;
        end else begin
          dx_q <= dx_q + 3'd1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // word position, window, scan copy and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= rc2[7:0];
      col_q <= cc1[7:0];
      pix_q <= pixel_i;
    end
    if (state_q == ST_READ && rd_cnt_q != 4'd0) begin
      for (int i = 0; i < Lines - 1; i++) colbuf_q[i] <= colbuf_q[i+1];
      colbuf_q[Lines-1] <= rdata;
    end
    if (state_q == ST_SHIFT) begin
      for (int y = 0; y < WinSize; y++) begin
        for (int x = 0; x < WinSize - 1; x++) win_q[y][x] <= win_q[y][x+1];
      end
      for (int y = 0; y < Lines; y++) win_q[y][WinSize-1] <= colbuf_q[y];
      win_q[WinSize-1][WinSize-1] <= pix_q;
    end
    // rotate the scan copy so the candidate sits at a fixed place
    if (state_q == ST_LOAD) begin
      wk_q <= win_q;
    end else if (state_q == ST_SCAN) begin
      for (int y = 0; y < WinSize; y++) begin
        for (int x = 0; x < WinSize; x++) begin
          if (dx_q == 3'd6) wk_q[y][x] <= wk_q[(y+1)%WinSize][(x+3)%WinSize];
          else wk_q[y][x] <= wk_q[y][(x+1)%WinSize];
        end
      end
    end
    if (out_load) begin
      filtered_q <= (den == '0) ? win_q[4][4] : quo;
      out_row_q  <= row_q - 8'd4;
      out_col_q  <= col_q - 8'd4;
    end
  end

  // line store addressing: the eight older rows, oldest first, starting at the slot of this row
  assign raddr = {row_q[SlotBits-1:0] + rd_cnt_q[SlotBits-1:0], col_q};
  assign waddr = {row_q[SlotBits-1:0], col_q};

  assign center_sum = patch_sum(win_q, 4, 4);
  assign cand_sum   = patch_sum(wk_q, 1, 1);

  nlmd_line_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (pix_q),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nlmd_weight u_weight (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (wctl),
    .decay_i      (decay_q),
    .center_sum_i (center_sum),
    .center_pix_i (win_q[4][4]),
    .cand_sum_i   (cand_sum),
    .cand_pix_i   (wk_q[1][1]),
    .busy_o       (wbusy),
    .num_o        (num),
    .den_o        (den)
  );

  nlmd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

`ifndef SYNTHESIS
  // weight pipeline is empty when the center term is folded in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !wbusy)
    else $error("weight pipeline busy at center fold-in");

  // weighted mean stays below 256 so the quotient fits eight bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (num < {den, 8'd0}) || (den == '0))
    else $error("weighted sum exceeds quotient range");

  // scan ends on the last search position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && state_d == ST_DRAIN) |=> (dx_q == 3'd0) && (dy_q == 3'd7))
    else $error("search scan ended early");

  // a result is emitted only for interior pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (row_q >= 8'(Lines)) && (col_q >= 8'(Lines)))
    else $error("border pixel emitted");
`endif

endmodule

[rtl/core/nlmd_line_mem.sv]
// ----------------------------------------------------------------------------
// nlmd_line_mem
// Line store: eight rows of pixels, one write and one registered read port.
// ----------------------------------------------------------------------------
module nlmd_line_mem
  import nlmd_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [MemAddrW-1:0] waddr_i,
  input  logic [7:0]          wdata_i,
  input  logic                re_i,
  input  logic [MemAddrW-1:0] raddr_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem_q [MemDepth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/nlmd_weight.sv]
// ----------------------------------------------------------------------------
// nlmd_weight
// Shared weight unit: one candidate patch per cycle through difference,
// square, decay scaling and table lookup, then weighted accumulation.
// ----------------------------------------------------------------------------
module nlmd_weight
  import nlmd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wctl_t           ctl_i,
  input  logic [15:0]     decay_i,
  input  logic [SumW-1:0] center_sum_i,
  input  logic [7:0]      center_pix_i,
  input  logic [SumW-1:0] cand_sum_i,
  input  logic [7:0]      cand_pix_i,
  output logic            busy_o,
  output logic [NumW-1:0] num_o,
  output logic [DenW-1:0] den_o
);

  logic            v1_q, v2_q, v3_q;
  logic            s1_q, s2_q, s3_q;
  logic [7:0]      p1_q, p2_q, p3_q;
  logic [SumW-1:0] diff_q;
  logic [SqW-1:0]  sq_q;
  logic [ExpW-1:0] ex_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [WgtW-1:0] wmax_q;

  logic [SumW-1:0]   diff_d;
  logic [ExpW-13:0]  expo;
  logic [WgtW-1:0]   wgt;
  logic [WgtW-1:0]   mul_a;
  logic [7:0]        mul_b;
  logic [ProdW-1:0]  prod;

  // absolute patch difference
  assign diff_d = (center_sum_i > cand_sum_i) ? center_sum_i - cand_sum_i
                                              : cand_sum_i - center_sum_i;

  // exponent in Q4 and table lookup, zero beyond the table
  assign expo = ex_q[ExpW-1:12];
  assign wgt  = (expo > (ExpW-12)'(ExpLimit)) ? '0 : ExpTab[expo[8:0]];

  // one multiplier for weight times pixel, reused for the center term
  assign mul_a = ctl_i.fin ? wmax_q : wgt;
  assign mul_b = ctl_i.fin ? center_pix_i : p3_q;
  assign prod  = ProdW'(mul_a) * ProdW'(mul_b);

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    s1_q   <= ctl_i.skip;
    p1_q   <= cand_pix_i;
    sq_q   <= SqW'(diff_q) * SqW'(diff_q);
    s2_q   <= s1_q;
    p2_q   <= p1_q;
    ex_q   <= ExpW'(sq_q) * ExpW'(decay_i);
    s3_q   <= s2_q;
    p3_q   <= p2_q;
  end

  // accumulate weighted sum, weight sum and largest weight
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q  <= '0;
      den_q  <= '0;
      wmax_q <= '0;
    end else if (ctl_i.fin) begin
      num_q <= num_q + NumW'(prod);
      den_q <= den_q + DenW'(wmax_q);
    end else if (v3_q && !s3_q) begin
      num_q <= num_q + NumW'(prod);
      den_q <= den_q + DenW'(wgt);
      if (wgt > wmax_q) begin
        wmax_q <= wgt;
      end
    end
  end

  assign busy_o = v1_q | v2_q | v3_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

[rtl/core/nlmd_div.sv]
// ----------------------------------------------------------------------------
// nlmd_div
// Restoring divider: one quotient bit per cycle, eight bits.
// ----------------------------------------------------------------------------
module nlmd_div
  import nlmd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [7:0]      quo_o
);

  logic            busy_q;
  logic            done_q;
  logic [2:0]      cnt_q;
  logic [NumW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [7:0]      quo_q;

  logic [NumW-1:0] trial;
  logic            fits;

  // shifted divisor for the current bit
  assign trial = NumW'(den_q) << cnt_q;
  assign fits  = rem_q >= trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd7;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: subtract where the shifted divisor fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial;
      end
      quo_q[cnt_q] <= fits;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
